// ===== src/mrh_pkg.sv =====
// ----------------------------------------------------------------------------
// mrh_pkg
// shared types and constants of the monotone radix heap
// ----------------------------------------------------------------------------
package mrh_pkg;

    localparam int KEY_BITS_DEF     = 32;
    localparam int BUCKET_DEPTH_DEF = 256;
    localparam int PAYLOAD_BITS_DEF = 20;

    localparam int IN_KEY_W  = 32;
    localparam int IN_PAY_W  = 20;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_PUSH    = 2'd1,
        CMD_POP     = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLACE,
        S_SCAN,
        S_SPLIT,
        S_MOVE_RD,
        S_MOVE_WAIT,
        S_MOVE_WR,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_DONE,
        S_OUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the input transaction
        logic restart;    // clear last key and captured key, for placing key zero
        logic place_in;   // place the captured entry
        logic scan_init;  // start lowest bucket search
        logic scan_step;  // advance search by one bucket
        logic split;      // take over bucket minimum as last key
        logic move_rd;    // read entry of split bucket
        logic move_wr;    // place the read entry again
        logic pop_rd;     // read top of bucket zero
        logic pop_done;   // drop top of bucket zero, latch result
        logic set_empty;  // report pop on empty heap
        logic out_valid;  // result register holds a transaction
    } t_ctrl;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       b0_empty;
        logic       scan_hit;
        logic       scan_end;
        logic       move_last;
    } t_stat;

endpackage

// ===== src/mrh_datapath.sv =====
// ----------------------------------------------------------------------------
// mrh_datapath
// bucket storage, fill counts, minima and the last extracted key
// ----------------------------------------------------------------------------
module mrh_datapath #(
    parameter int KEY_BITS     = mrh_pkg::KEY_BITS_DEF,
    parameter int BUCKET_DEPTH = mrh_pkg::BUCKET_DEPTH_DEF,
    parameter int PAYLOAD_BITS = mrh_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mrh_pkg::t_ctrl                i_ctrl,
    output mrh_pkg::t_stat                o_stat,
    input  logic [1:0]                    i_command,
    input  logic [mrh_pkg::IN_KEY_W-1:0]  i_key,
    input  logic [mrh_pkg::IN_PAY_W-1:0]  i_payload,
    output logic [mrh_pkg::IN_KEY_W-1:0]  o_out_key,
    output logic [mrh_pkg::IN_PAY_W-1:0]  o_out_payload,
    output logic [1:0]                    o_status
);

    localparam int NB    = KEY_BITS + 1;
    localparam int BW    = $clog2(NB);
    localparam int DW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int AW    = BW + DW;
    localparam int EW    = KEY_BITS + PAYLOAD_BITS;
    localparam int KW    = (KEY_BITS < mrh_pkg::IN_KEY_W) ? KEY_BITS : mrh_pkg::IN_KEY_W;
    localparam int PW    = (PAYLOAD_BITS < mrh_pkg::IN_PAY_W) ? PAYLOAD_BITS
                                                                : mrh_pkg::IN_PAY_W;

    // each bucket owns a power-of-two slot range, addressed as {bucket, slot}
    logic [EW-1:0]       r_mem [NB*(2**DW)];
    logic [EW-1:0]       r_rd;
    logic [FW-1:0]       r_fill [NB];
    logic [KEY_BITS-1:0] r_min [NB];
    logic [KEY_BITS-1:0] r_last;

    logic [1:0]              r_cmd;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [BW-1:0]           r_scan;
    logic [FW-1:0]           r_cnt;
    logic [FW-1:0]           r_n;

    logic [mrh_pkg::IN_KEY_W-1:0] r_okey;
    logic [mrh_pkg::IN_PAY_W-1:0] r_opay;
    logic [1:0]                   r_ostat;

    // entry to be placed: captured input or entry read back
    logic [KEY_BITS-1:0]     pl_key;
    logic [PAYLOAD_BITS-1:0] pl_pay;
    logic [KEY_BITS-1:0]     pl_x;
    logic [BW-1:0]           pl_b;
    logic                    pl_en;
    logic                    pl_full;
    logic [AW-1:0]           pl_addr;
    logic [AW-1:0]           rd_addr;
    logic [FW-1:0]           top;

    always_comb begin
        if (i_ctrl.move_wr) begin
            pl_key = r_rd[EW-1:PAYLOAD_BITS];
            pl_pay = r_rd[PAYLOAD_BITS-1:0];
        end else begin
            pl_key = r_key;
            pl_pay = r_pay;
        end
        pl_x = pl_key ^ r_last;
        pl_b = '0;
        for (int j = 0; j < KEY_BITS; j++) begin
            if (pl_x[j]) begin
                pl_b = BW'(j + 1);
            end
        end
        pl_en   = i_ctrl.place_in || i_ctrl.move_wr;
        pl_full = (r_fill[pl_b] >= FW'(BUCKET_DEPTH));
        pl_addr = {pl_b, r_fill[pl_b][DW-1:0]};
        top     = r_fill[0] - FW'(1);
        if (i_ctrl.pop_rd) begin
            rd_addr = {BW'(0), top[DW-1:0]};
        end else begin
            rd_addr = {r_scan, r_cnt[DW-1:0]};
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (pl_en && !pl_full) begin
            r_mem[pl_addr] <= {pl_key, pl_pay};
        end
        r_rd <= r_mem[rd_addr];
    end

    // input capture, with restart turning into a placement of key zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_key <= KEY_BITS'(i_key[KW-1:0]);
            r_pay <= PAYLOAD_BITS'(i_payload[PW-1:0]);
        end else if (i_ctrl.restart) begin
            r_key <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NB; j++) begin
                r_fill[j] <= '0;
                r_min[j]  <= '1;
            end
            r_last  <= '0;
            r_scan  <= '0;
            r_cnt   <= '0;
            r_n     <= '0;
            r_okey  <= '0;
            r_opay  <= '0;
            r_ostat <= mrh_pkg::ST_OK;
        end else begin
            if (i_ctrl.load) begin
                r_okey  <= '0;
                r_opay  <= '0;
                r_ostat <= mrh_pkg::ST_OK;
            end
            if (i_ctrl.restart) begin
                r_last <= '0;
            end
            if (pl_en) begin
                if (pl_full) begin
                    if (i_ctrl.place_in) begin
                        r_ostat <= mrh_pkg::ST_FULL;
                    end
                end else begin
                    r_fill[pl_b] <= r_fill[pl_b] + FW'(1);
                    if (pl_key < r_min[pl_b]) begin
                        r_min[pl_b] <= pl_key;
                    end
                end
            end
            if (i_ctrl.scan_init) begin
                r_scan <= BW'(1);
            end else if (i_ctrl.scan_step) begin
                r_scan <= r_scan + BW'(1);
            end
            if (i_ctrl.split) begin
                r_last         <= r_min[r_scan];
                r_n            <= r_fill[r_scan];
                r_fill[r_scan] <= '0;
                r_min[r_scan]  <= '1;
                r_cnt          <= '0;
            end
            if (i_ctrl.move_wr) begin
                r_cnt <= r_cnt + FW'(1);
            end
            if (i_ctrl.set_empty) begin
                r_ostat <= mrh_pkg::ST_EMPTY;
            end
            if (i_ctrl.pop_done) begin
                r_okey    <= mrh_pkg::IN_KEY_W'(r_rd[EW-1:PAYLOAD_BITS]);
                r_opay    <= mrh_pkg::IN_PAY_W'(r_rd[PAYLOAD_BITS-1:0]);
                r_fill[0] <= top;
                if (top == '0) begin
                    r_min[0] <= '1;
                end
            end
        end
    end

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.b0_empty  = (r_fill[0] == '0);
        o_stat.scan_hit  = (r_fill[r_scan] != '0);
        o_stat.scan_end  = (r_scan == BW'(NB - 1));
        o_stat.move_last = (r_cnt + FW'(1) >= r_n);
    end

    assign o_out_key     = r_okey;
    assign o_out_payload = r_opay;
    assign o_status      = r_ostat;

endmodule

// ===== src/mrh_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrh_ctrl
// command sequencer of the monotone radix heap
// ----------------------------------------------------------------------------
module mrh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  mrh_pkg::t_stat i_stat,
    output mrh_pkg::t_ctrl o_ctrl
);

    mrh_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mrh_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = mrh_pkg::S_PLACE;
                end
            end
            mrh_pkg::S_PLACE: begin
                unique case (i_stat.cmd)
                    mrh_pkg::CMD_RESTART: begin
                        o_ctrl.restart = 1'b1;
                        n_state        = mrh_pkg::S_SPLIT;
                    end
                    mrh_pkg::CMD_PUSH: begin
                        o_ctrl.place_in = 1'b1;
                        n_state         = mrh_pkg::S_OUT;
                    end
                    mrh_pkg::CMD_POP: begin
                        o_ctrl.scan_init = 1'b1;
                        n_state = i_stat.b0_empty ? mrh_pkg::S_SCAN : mrh_pkg::S_POP_RD;
                    end
                    default: n_state = mrh_pkg::S_OUT;
                endcase
            end
            mrh_pkg::S_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_ctrl.split = 1'b1;
                    n_state      = mrh_pkg::S_MOVE_RD;
                end else if (i_stat.scan_end) begin
                    o_ctrl.set_empty = 1'b1;
                    n_state          = mrh_pkg::S_OUT;
                end else begin
                    o_ctrl.scan_step = 1'b1;
                end
            end
            mrh_pkg::S_SPLIT: begin
                // restart placement, after last key is cleared
                o_ctrl.place_in = 1'b1;
                n_state         = mrh_pkg::S_OUT;
            end
            mrh_pkg::S_MOVE_RD: begin
                o_ctrl.move_rd = 1'b1;
                n_state        = mrh_pkg::S_MOVE_WAIT;
            end
            mrh_pkg::S_MOVE_WAIT: begin
                n_state = mrh_pkg::S_MOVE_WR;
            end
            mrh_pkg::S_MOVE_WR: begin
                o_ctrl.move_wr = 1'b1;
                n_state = i_stat.move_last ? mrh_pkg::S_POP_RD : mrh_pkg::S_MOVE_RD;
            end
            mrh_pkg::S_POP_RD: begin
                o_ctrl.pop_rd = 1'b1;
                n_state       = mrh_pkg::S_POP_WAIT;
            end
            mrh_pkg::S_POP_WAIT: begin
                // keep the read address on the top of bucket zero
                o_ctrl.pop_rd = 1'b1;
                n_state       = mrh_pkg::S_POP_DONE;
            end
            mrh_pkg::S_POP_DONE: begin
                o_ctrl.pop_done = 1'b1;
                n_state         = mrh_pkg::S_OUT;
            end
            mrh_pkg::S_OUT: begin
                o_ctrl.out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = mrh_pkg::S_IDLE;
                end
            end
            default: n_state = mrh_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = o_ctrl.out_valid;

endmodule

// ===== src/monotone_radix_heap_top.sv =====
// ----------------------------------------------------------------------------
// monotone_radix_heap_top
// monotone radix heap priority queue with restart, push and pop commands
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  in      | i_in_valid/o_in_ready, command/key/payload   | one command per transaction
//  out     | o_out_valid/i_out_ready, key/payload/status  | one result per transaction
//
//  push loads and places; restart loads, clears the last key and places key zero;
//  each plus the output handshake; pop from a filled bucket zero reads, waits and
//  drops its top, else the bucket search looks at one bucket at a time and the split
//  moves each entry through the registered entry memory read (read, wait, write back)
//  synchronous active-low reset clears fills, minima and last key at once
//  the entry memory is never cleared; only written entries are read
//  a stalled result holds the block; a new command is taken after delivery
// ----------------------------------------------------------------------------
module monotone_radix_heap_top #(
    parameter int KEY_BITS     = mrh_pkg::KEY_BITS_DEF,
    parameter int BUCKET_DEPTH = mrh_pkg::BUCKET_DEPTH_DEF,
    parameter int PAYLOAD_BITS = mrh_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [19:0] i_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_key,
    output logic [19:0] o_out_payload,
    output logic [1:0]  o_status
);

    // controller to datapath commands and status
    mrh_pkg::t_ctrl ctrl;
    mrh_pkg::t_stat stat;

    mrh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    mrh_datapath #(
        .KEY_BITS     (KEY_BITS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_status      (o_status)
    );

endmodule
